// ===== src/tlge_pkg.sv =====
// ----------------------------------------------------------------------------
// tlge_pkg
// Shared types and constants for the toroidal life generation engine.
// ----------------------------------------------------------------------------
package tlge_pkg;

  // default grid capacity
  localparam int MaxWidthDef  = 64;
  localparam int MaxHeightDef = 64;

  // field widths
  localparam int FuncW   = 2;
  localparam int RowW    = 6;
  localparam int ColW    = 6;
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 1;
  localparam int PopW    = 13;
  localparam int InDataW  = 16;
  localparam int OutDataW = 16;

  // life rule
  localparam logic [3:0] SurviveLow  = 4'd2;
  localparam logic [3:0] SurviveHigh = 4'd3;
  localparam logic [3:0] BirthCount  = 4'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegGridWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegGridHeight = 1'b1;

  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_STEP  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_CELL_GET,
    ST_LOAD_UP,
    ST_LOAD_MID,
    ST_LOAD_DN,
    ST_LOAD_END,
    ST_COLS,
    ST_ROW_WR,
    ST_ROW_LD,
    ST_RESP
  } state_e;

  // 3x3 neighborhood taken from the row window
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] mid;
    logic [2:0] below;
  } nbhd_t;

endpackage

// ===== src/tlge_cell_unit.sv =====
// ----------------------------------------------------------------------------
// tlge_cell_unit
// Life rule for one cell: counts the wrapped 3x3 window minus the center.
// ----------------------------------------------------------------------------
module tlge_cell_unit (
  input  tlge_pkg::nbhd_t win_i,
  output logic            next_o
);
  import tlge_pkg::*;

  logic [3:0] sum9;
  logic [3:0] ncnt;
  logic       alive;

  always_comb begin
    sum9 = 4'(win_i.above[0]) + 4'(win_i.above[1]) + 4'(win_i.above[2])
         + 4'(win_i.mid[0])   + 4'(win_i.mid[1])   + 4'(win_i.mid[2])
         + 4'(win_i.below[0]) + 4'(win_i.below[1]) + 4'(win_i.below[2]);
    // center is taken out once, even when the window revisits it
    alive = win_i.mid[1];
    ncnt  = sum9 - 4'(alive);
    if (alive) begin
      next_o = (ncnt == SurviveLow) || (ncnt == SurviveHigh);
    end else begin
      next_o = (ncnt == BirthCount);
    end
  end

endmodule

// ===== src/toroidal_life_generation_engine.sv =====
// ----------------------------------------------------------------------------
// toroidal_life_generation_engine
// Toroidal Conway life grid with cell write, cell read and one-generation step.
// ----------------------------------------------------------------------------
// The grid is held as one row per memory word, and a generation is computed in
// place: a three-row window slides down the grid while a single cell unit
// evaluates one cell per cycle, with a saved copy of the original top row for
// the wrap at the bottom. Step time for the active size w by h is set by the
// one cell unit and the single read port of the row memory. A cell write reads
// the row and writes it back with the cell changed; a cell read picks the cell
// from the row it reads. Only one transaction is in flight at a time; the
// result sits in an output register, so a new item is taken while it waits.
// Row valid flags read the grid as all dead after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module toroidal_life_generation_engine #(
  parameter int MAX_WIDTH  = tlge_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = tlge_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [tlge_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlge_pkg::CfgW-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tlge_pkg::InDataW-1:0]  s_axis_tdata,   // row, column, cell_in
  input  logic [tlge_pkg::FuncW-1:0]    s_axis_tuser,   // func
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tlge_pkg::OutDataW-1:0] m_axis_tdata    // cell_out, population, extinct
);
  import tlge_pkg::*;

  localparam int CIW = $clog2(MAX_WIDTH);
  localparam int RIW = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WEW = (WW > CfgW) ? WW : CfgW;
  localparam int HEW = (HW > CfgW) ? HW : CfgW;
  localparam int CCW = (WW > ColW) ? WW : ColW;
  localparam int RCW = (HW > RowW) ? HW : RowW;

  // configuration
  logic [CfgW-1:0] grid_width_q, grid_height_q;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;

  // item
  func_e           func_q;
  logic [RowW-1:0] row_in_q;
  logic [ColW-1:0] col_in_q;
  logic            cell_in_q;
  logic            in_grid;

  state_e state_q, state_d;

  // row memory
  logic [MAX_WIDTH-1:0] grid_mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_vld_q;
  logic                  mem_we;
  logic [RIW-1:0]        mem_waddr, mem_raddr;
  logic [MAX_WIDTH-1:0]  mem_wdata;
  logic [MAX_WIDTH-1:0]  rd_q;
  logic                  rd_vld_q;
  logic [MAX_WIDTH-1:0]  rd_eff;

  // step window
  logic [MAX_WIDTH-1:0] above_q, mid_q, below_q, top_q, new_row_q;
  logic [RIW-1:0]       r_q;
  logic [CIW-1:0]       c_q;
  logic [CIW-1:0]       cl, cr;
  logic                 last_col, last_row, wrap_below;
  nbhd_t                win;
  logic                 next_cell;

  // results
  logic [PopW-1:0]      pop_q;
  logic                 alive_q;
  logic                 cell_q;
  logic                 out_vld_q;
  logic [OutDataW-1:0]  out_data_q;
  logic                 out_free;

  assign out_free = !out_vld_q || m_axis_tready;

  // effective sizes: zero acts as one, too large acts as the maximum
  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = WW'(1);
    end else if (WEW'(grid_width_q) > WEW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      h_eff = HW'(1);
    end else if (HEW'(grid_height_q) > HEW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(grid_height_q);
    end
  end

  assign in_grid = (RCW'(row_in_q) < RCW'(h_eff)) && (CCW'(col_in_q) < CCW'(w_eff));
  assign rd_eff = rd_vld_q ? rd_q : '0;

  // column neighbors with horizontal wrap
  assign last_col   = (WW'(c_q) == WW'(w_eff - WW'(1)));
  assign last_row   = (HW'(r_q) == HW'(h_eff - HW'(1)));
  // the row below the current one is the original top row
  assign wrap_below = ((HW + 1)'(r_q) + (HW + 1)'(1) == (HW + 1)'(h_eff));
  assign cl = (c_q == '0) ? CIW'(w_eff - WW'(1)) : CIW'(c_q - CIW'(1));
  assign cr = last_col ? '0 : CIW'(c_q + CIW'(1));

  always_comb begin
    win.above = {above_q[cr], above_q[c_q], above_q[cl]};
    win.mid   = {mid_q[cr],   mid_q[c_q],   mid_q[cl]};
    win.below = {below_q[cr], below_q[c_q], below_q[cl]};
  end

  tlge_cell_unit u_cell (
    .win_i  (win),
    .next_o (next_cell)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (func_e'(s_axis_tuser))
            FUNC_WRITE, FUNC_READ: state_d = ST_CELL_RD;
            FUNC_STEP:             state_d = ST_LOAD_UP;
            default:               state_d = ST_RESP;
          endcase
        end
      end
      ST_CELL_RD:  state_d = (func_q == FUNC_WRITE) ? ST_CELL_WR : ST_CELL_GET;
      ST_CELL_WR:  state_d = ST_RESP;
      ST_CELL_GET: state_d = ST_RESP;
      ST_LOAD_UP:  state_d = ST_LOAD_MID;
      ST_LOAD_MID: state_d = ST_LOAD_DN;
      ST_LOAD_DN:  state_d = ST_LOAD_END;
      ST_LOAD_END: state_d = ST_COLS;
      ST_COLS: begin
        if (last_col) begin
          state_d = ST_ROW_WR;
        end
      end
      ST_ROW_WR:   state_d = last_row ? ST_RESP : ST_ROW_LD;
      ST_ROW_LD:   state_d = ST_COLS;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // memory control and handshake
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mem_we        = 1'b0;
    mem_waddr     = r_q;
    mem_wdata     = new_row_q;
    mem_raddr     = RIW'(row_in_q);
    unique case (state_q)
      ST_CELL_WR: begin
        mem_we    = in_grid;
        mem_waddr = RIW'(row_in_q);
        mem_wdata = rd_eff;
        mem_wdata[CIW'(col_in_q)] = cell_in_q;
      end
      ST_LOAD_UP:  mem_raddr = RIW'(h_eff - HW'(1));
      ST_LOAD_MID: mem_raddr = '0;
      ST_LOAD_DN:  mem_raddr = (h_eff == HW'(1)) ? '0 : RIW'(1);
      ST_ROW_WR: begin
        mem_we    = 1'b1;
        mem_raddr = RIW'(r_q + RIW'(2));
      end
      default: begin
      end
    endcase
  end

  // row memory, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= grid_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[mem_raddr];
      if (mem_we) begin
        row_vld_q[mem_waddr] <= 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      grid_width_q  <= CfgW'(64);
      grid_height_q <= CfgW'(64);
      out_vld_q     <= 1'b0;
      r_q           <= '0;
      c_q           <= '0;
      func_q        <= FUNC_NONE;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegGridWidth:  grid_width_q  <= cfg_data_i;
          RegGridHeight: grid_height_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if ((state_q == ST_RESP) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        func_q <= func_e'(s_axis_tuser);
        r_q    <= '0;
        c_q    <= '0;
      end
      if (state_q == ST_COLS) begin
        c_q <= last_col ? '0 : CIW'(c_q + CIW'(1));
      end
      if ((state_q == ST_ROW_WR) && !last_row) begin
        r_q <= RIW'(r_q + RIW'(1));
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      row_in_q  <= s_axis_tdata[RowW-1:0];
      col_in_q  <= s_axis_tdata[RowW+ColW-1:RowW];
      cell_in_q <= s_axis_tdata[RowW+ColW];
      pop_q     <= '0;
      alive_q   <= 1'b0;
      cell_q    <= 1'b0;
    end
    unique case (state_q)
      ST_CELL_GET: cell_q <= in_grid & rd_eff[CIW'(col_in_q)];
      ST_LOAD_MID: above_q <= rd_eff;
      ST_LOAD_DN: begin
        mid_q     <= rd_eff;
        top_q     <= rd_eff;
        new_row_q <= rd_eff;
      end
      ST_LOAD_END: below_q <= rd_eff;
      ST_COLS: begin
        new_row_q[c_q] <= next_cell;
        if (next_cell) begin
          alive_q <= 1'b1;
          if (pop_q != '1) begin
            pop_q <= PopW'(pop_q + PopW'(1));
          end
        end
      end
      ST_ROW_WR: begin
        above_q   <= mid_q;
        mid_q     <= below_q;
        new_row_q <= below_q;
      end
      // bottom row wraps to the original top row, already overwritten
      ST_ROW_LD: below_q <= wrap_below ? top_q : rd_eff;
      ST_RESP: begin
        if (out_free) begin
          if (func_q == FUNC_STEP) begin
            out_data_q <= {1'b0, !alive_q, pop_q, 1'b0};
          end else if (func_q == FUNC_READ) begin
            out_data_q <= {1'b0, 1'b0, PopW'(0), cell_q};
          end else begin
            out_data_q <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
